### hdl/lfcr_pkg.sv
// Shared constants, codes and types for the LED frame command receiver.
// Used by the channel interfaces, the frame store and the top level. No dependencies.
package lfcr_pkg;

    // Frame geometry
    localparam int unsigned PIXEL_COUNT = 256;
    localparam int unsigned IDX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int unsigned CNT_W       = $clog2(3 * PIXEL_COUNT + 2);

    localparam logic [8:0]       PIX_LIM  = 9'(PIXEL_COUNT);
    localparam logic [CNT_W-1:0] DYN_LAST = CNT_W'(3 * PIXEL_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PIXEL_COUNT - 1);

    // Input opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Modes
    localparam logic [2:0] MODE_WAIT   = 3'd0;
    localparam logic [2:0] MODE_COLOR  = 3'd1;
    localparam logic [2:0] MODE_DYN    = 3'd2;
    localparam logic [2:0] MODE_PIXEL  = 3'd3;
    localparam logic [2:0] MODE_BRIGHT = 3'd4;

    // Result events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHOW  = 2'd1;
    localparam logic [1:0] EV_BLANK = 2'd2;

    // Command bytes
    localparam logic [7:0] CMD_COLOR  = 8'd22;
    localparam logic [7:0] CMD_DYN    = 8'd23;
    localparam logic [7:0] CMD_PIXEL  = 8'd24;
    localparam logic [7:0] CMD_BRIGHT = 8'd25;
    localparam logic [7:0] CMD_BLANK  = 8'd27;

    localparam logic [7:0] TICK_SAT = 8'd255;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DYN_TO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_TO = 2'd3;

    // Reset values
    localparam logic [7:0] RST_COLOR_TO  = 8'd100;
    localparam logic [7:0] RST_PIXEL_TO  = 8'd50;
    localparam logic [7:0] RST_DYN_TO    = 8'd200;
    localparam logic [7:0] RST_BRIGHT_TO = 8'd50;
    localparam logic [7:0] BYTE_FULL     = 8'd255;

    // Color channel inside a dynamic upload
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Frame store access, one port
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        logic [23:0]      wdata;
    } lfcr_mem_req_t;

endpackage

### hdl/lfcr_if.sv
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on lfcr_pkg for field widths.
interface lfcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output data_byte, output read_index,
                    input ready);
    modport sink (input valid, input opcode, input data_byte, input read_index,
                  output ready);
endinterface

interface lfcr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] brightness;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic [2:0] mode;

    modport source (output valid, output event_res, output brightness, output read_red,
                    output read_green, output read_blue, output mode, input ready);
    modport sink (input valid, input event_res, input brightness, input read_red,
                  input read_green, input read_blue, input mode, output ready);
endinterface

interface lfcr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lfcr_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/led_frame_command_receiver_core.sv
// LED frame command receiver: one result word for every input word, in order. From S_IDLE
// an accepted word goes straight to S_DONE, which loads the output register once it is free,
// for a tick, a command byte, an out-of-range read, a brightness byte, a data byte that
// only fills a command buffer or a byte that times out a dynamic upload. It passes through
// S_RDATA for a pixel read, through S_RMW for a dynamic upload pixel byte (one
// read-modify-write of the pixel) and through S_PWR for a byte that completes or times out
// a pixel command (one pixel write) before S_DONE. A byte that completes or times out a
// color command passes through S_FILL, where the fill writes every frame store entry
// through its single write port, one per cycle. A new input word is accepted the cycle
// after the previous result is loaded into the output register, even if that result has
// not been taken yet. A word therefore holds the input until its result is loaded, plus
// any wait for a full output register. Register writes are always accepted.
// The frame store reads as black after reset without a clearing pass.
// Depends on lfcr_pkg, lfcr_if (channel interfaces) and lfcr_frame_store.
module led_frame_command_receiver_core (
    input  logic         clk,
    input  logic         rst_n,
    lfcr_in_if.sink      item_in,
    lfcr_out_if.source   result_out,
    lfcr_cfg_if.sink     cfg
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDATA = 3'd1;
    localparam logic [2:0] S_RMW   = 3'd2;
    localparam logic [2:0] S_PWR   = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Command state
    logic [2:0]                 mode_reg, mode_next;
    logic [lfcr_pkg::CNT_W-1:0] bcnt_reg, bcnt_next;
    logic                       timer_reg, timer_next;
    logic [7:0]                 elapsed_reg, elapsed_next;
    logic [7:0]                 color_reg [4];
    logic [7:0]                 color_next [4];
    logic [7:0]                 pix_reg [5];
    logic [7:0]                 pix_next [5];
    logic [7:0]                 sbright_reg, sbright_next;
    logic [lfcr_pkg::IDX_W-1:0] dpx_reg, dpx_next;
    logic [1:0]                 dch_reg, dch_next;

    // Timeout registers
    logic [7:0] to_color_reg, to_pixel_reg, to_dyn_reg, to_bright_reg;

    // Frame store work
    logic [lfcr_pkg::IDX_W-1:0] fill_reg, fill_next;
    logic [lfcr_pkg::IDX_W-1:0] wr_addr_reg, wr_addr_next;
    logic [1:0]                 wr_ch_reg, wr_ch_next;
    logic [7:0]                 wr_byte_reg, wr_byte_next;
    lfcr_pkg::lfcr_mem_req_t    mem_req;
    logic [23:0]                rd_data;
    logic [23:0]                merged;

    // Result under construction and output register
    logic [1:0]  res_event_reg, res_event_next;
    logic [7:0]  res_bright_reg, res_bright_next;
    logic [23:0] res_rgb_reg, res_rgb_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_event_reg, out_event_next;
    logic [7:0]  out_bright_reg, out_bright_next;
    logic [23:0] out_rgb_reg, out_rgb_next;
    logic [2:0]  out_mode_reg, out_mode_next;

    // Decode helpers
    logic                       in_fire;
    logic                       as_cmd;
    logic                       commit_old;
    logic                       fin;
    logic [2:0]                 pk;
    logic [lfcr_pkg::CNT_W-1:0] bcnt_inc;
    logic [7:0]                 active_to;

    assign item_in.ready = (state_reg == S_IDLE);
    assign in_fire       = item_in.valid && item_in.ready;
    assign bcnt_inc      = bcnt_reg + lfcr_pkg::CNT_W'(1);
    assign cfg.ready     = 1'b1;

    lfcr_frame_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Timeout of the command in progress
    always_comb
    begin
        case (mode_reg)
            lfcr_pkg::MODE_COLOR: active_to = to_color_reg;
            lfcr_pkg::MODE_DYN:   active_to = to_dyn_reg;
            lfcr_pkg::MODE_PIXEL: active_to = to_pixel_reg;
            default:              active_to = to_bright_reg;
        endcase
    end

    // Replace one channel of the pixel read back for a dynamic upload byte
    always_comb
    begin
        merged = rd_data;
        case (wr_ch_reg)
            lfcr_pkg::CH_RED:   merged[23:16] = wr_byte_reg;
            lfcr_pkg::CH_GREEN: merged[15:8]  = wr_byte_reg;
            default:            merged[7:0]   = wr_byte_reg;
        endcase
    end

    // Main sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        bcnt_next       = bcnt_reg;
        timer_next      = timer_reg;
        elapsed_next    = elapsed_reg;
        color_next      = color_reg;
        pix_next        = pix_reg;
        sbright_next    = sbright_reg;
        dpx_next        = dpx_reg;
        dch_next        = dch_reg;
        fill_next       = fill_reg;
        wr_addr_next    = wr_addr_reg;
        wr_ch_next      = wr_ch_reg;
        wr_byte_next    = wr_byte_reg;
        res_event_next  = res_event_reg;
        res_bright_next = res_bright_reg;
        res_rgb_next    = res_rgb_reg;
        out_event_next  = out_event_reg;
        out_bright_next = out_bright_reg;
        out_rgb_next    = out_rgb_reg;
        out_mode_next   = out_mode_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        mem_req         = '0;
        as_cmd          = 1'b0;
        commit_old      = 1'b0;
        fin             = 1'b0;
        pk              = 3'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_event_next  = lfcr_pkg::EV_NONE;
                    res_bright_next = 8'd0;
                    res_rgb_next    = 24'd0;
                    state_next      = S_DONE;
                    case (item_in.opcode)
                        lfcr_pkg::OP_TICK:
                        begin
                            // saturate so a 255 timeout never expires
                            if (timer_reg && elapsed_reg != lfcr_pkg::TICK_SAT)
                            begin
                                elapsed_next = elapsed_reg + 8'd1;
                            end
                        end
                        lfcr_pkg::OP_READ:
                        begin
                            if ({1'b0, item_in.read_index} < lfcr_pkg::PIX_LIM)
                            begin
                                mem_req.rd_en = 1'b1;
                                mem_req.addr  = item_in.read_index[lfcr_pkg::IDX_W-1:0];
                                state_next    = S_RDATA;
                            end
                        end
                        lfcr_pkg::OP_BYTE:
                        begin
                            as_cmd = (mode_reg == lfcr_pkg::MODE_WAIT);
                            if (!as_cmd)
                            begin
                                if (!timer_reg)
                                begin
                                    // first data byte arms the timeout
                                    timer_next   = 1'b1;
                                    elapsed_next = 8'd0;
                                end
                                else if (elapsed_reg > active_to)
                                begin
                                    // expired: commit partial data, byte becomes a command
                                    commit_old     = 1'b1;
                                    as_cmd         = 1'b1;
                                    res_event_next = lfcr_pkg::EV_SHOW;
                                    case (mode_reg)
                                        lfcr_pkg::MODE_COLOR:
                                        begin
                                            res_bright_next = color_reg[0];
                                            state_next      = S_FILL;
                                        end
                                        lfcr_pkg::MODE_PIXEL:
                                        begin
                                            res_bright_next = pix_reg[1];
                                            state_next      = S_PWR;
                                        end
                                        default:
                                        begin
                                            res_bright_next = sbright_reg;
                                        end
                                    endcase
                                    bcnt_next  = '0;
                                    dpx_next   = '0;
                                    dch_next   = lfcr_pkg::CH_RED;
                                    timer_next = 1'b0;
                                    mode_next  = lfcr_pkg::MODE_WAIT;
                                end
                            end

                            if (as_cmd)
                            begin
                                case (item_in.data_byte)
                                    lfcr_pkg::CMD_COLOR:  mode_next = lfcr_pkg::MODE_COLOR;
                                    lfcr_pkg::CMD_DYN:    mode_next = lfcr_pkg::MODE_DYN;
                                    lfcr_pkg::CMD_PIXEL:  mode_next = lfcr_pkg::MODE_PIXEL;
                                    lfcr_pkg::CMD_BRIGHT: mode_next = lfcr_pkg::MODE_BRIGHT;
                                    lfcr_pkg::CMD_BLANK:
                                    begin
                                        // a show from the timeout hides the blank
                                        if (!commit_old)
                                        begin
                                            res_event_next = lfcr_pkg::EV_BLANK;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            else
                            begin
                                case (mode_reg)
                                    lfcr_pkg::MODE_COLOR:
                                    begin
                                        color_next[bcnt_reg[1:0]] = item_in.data_byte;
                                        bcnt_next = bcnt_inc;
                                        if (bcnt_inc > lfcr_pkg::CNT_W'(3))
                                        begin
                                            fin             = 1'b1;
                                            res_bright_next = color_reg[0];
                                            state_next      = S_FILL;
                                        end
                                    end
                                    lfcr_pkg::MODE_PIXEL:
                                    begin
                                        pk = (bcnt_reg > lfcr_pkg::CNT_W'(4)) ? 3'd4
                                                                              : bcnt_reg[2:0];
                                        pix_next[pk] = item_in.data_byte;
                                        bcnt_next    = bcnt_inc;
                                        if (bcnt_inc > lfcr_pkg::CNT_W'(4))
                                        begin
                                            fin             = 1'b1;
                                            res_bright_next = pix_reg[1];
                                            state_next      = S_PWR;
                                        end
                                    end
                                    lfcr_pkg::MODE_DYN:
                                    begin
                                        if (bcnt_reg == '0)
                                        begin
                                            sbright_next = item_in.data_byte;
                                        end
                                        else
                                        begin
                                            // read the pixel, merge the channel next cycle
                                            mem_req.rd_en = 1'b1;
                                            mem_req.addr  = dpx_reg;
                                            wr_addr_next  = dpx_reg;
                                            wr_ch_next    = dch_reg;
                                            wr_byte_next  = item_in.data_byte;
                                            state_next    = S_RMW;
                                            if (dch_reg == lfcr_pkg::CH_BLUE)
                                            begin
                                                dch_next = lfcr_pkg::CH_RED;
                                                dpx_next = dpx_reg + lfcr_pkg::IDX_W'(1);
                                            end
                                            else
                                            begin
                                                dch_next = dch_reg + 2'd1;
                                            end
                                        end
                                        bcnt_next = bcnt_inc;
                                        if (bcnt_inc > lfcr_pkg::DYN_LAST)
                                        begin
                                            fin             = 1'b1;
                                            res_bright_next = sbright_reg;
                                        end
                                    end
                                    default:
                                    begin
                                        sbright_next    = item_in.data_byte;
                                        fin             = 1'b1;
                                        res_bright_next = item_in.data_byte;
                                    end
                                endcase

                                if (fin)
                                begin
                                    res_event_next = lfcr_pkg::EV_SHOW;
                                    bcnt_next      = '0;
                                    dpx_next       = '0;
                                    dch_next       = lfcr_pkg::CH_RED;
                                    timer_next     = 1'b0;
                                    mode_next      = lfcr_pkg::MODE_WAIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RDATA:
            begin
                res_rgb_next = rd_data;
                state_next   = S_DONE;
            end

            S_RMW:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = wr_addr_reg;
                mem_req.wdata = merged;
                state_next    = S_DONE;
            end

            S_PWR:
            begin
                // drop writes beyond the frame
                if ({1'b0, pix_reg[0]} < lfcr_pkg::PIX_LIM)
                begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = pix_reg[0][lfcr_pkg::IDX_W-1:0];
                    mem_req.wdata = {pix_reg[2], pix_reg[3], pix_reg[4]};
                end
                state_next = S_DONE;
            end

            S_FILL:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = fill_reg;
                mem_req.wdata = {color_reg[1], color_reg[2], color_reg[3]};
                if (fill_reg == lfcr_pkg::IDX_LAST)
                begin
                    fill_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    fill_next = fill_reg + lfcr_pkg::IDX_W'(1);
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_event_next  = res_event_reg;
                    out_bright_next = res_bright_reg;
                    out_rgb_next    = res_rgb_reg;
                    out_mode_next   = mode_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and command state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= lfcr_pkg::MODE_COLOR;
            bcnt_reg      <= '0;
            timer_reg     <= 1'b0;
            elapsed_reg   <= 8'd0;
            color_reg[0]  <= lfcr_pkg::BYTE_FULL;
            color_reg[1]  <= lfcr_pkg::BYTE_FULL;
            color_reg[2]  <= 8'd0;
            color_reg[3]  <= 8'd0;
            pix_reg[0]    <= 8'd0;
            pix_reg[1]    <= lfcr_pkg::BYTE_FULL;
            pix_reg[2]    <= 8'd0;
            pix_reg[3]    <= 8'd0;
            pix_reg[4]    <= lfcr_pkg::BYTE_FULL;
            sbright_reg   <= lfcr_pkg::BYTE_FULL;
            dpx_reg       <= '0;
            dch_reg       <= lfcr_pkg::CH_RED;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            bcnt_reg      <= bcnt_next;
            timer_reg     <= timer_next;
            elapsed_reg   <= elapsed_next;
            color_reg     <= color_next;
            pix_reg       <= pix_next;
            sbright_reg   <= sbright_next;
            dpx_reg       <= dpx_next;
            dch_reg       <= dch_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg    <= wr_addr_next;
        wr_ch_reg      <= wr_ch_next;
        wr_byte_reg    <= wr_byte_next;
        res_event_reg  <= res_event_next;
        res_bright_reg <= res_bright_next;
        res_rgb_reg    <= res_rgb_next;
        out_event_reg  <= out_event_next;
        out_bright_reg <= out_bright_next;
        out_rgb_reg    <= out_rgb_next;
        out_mode_reg   <= out_mode_next;
    end

    // Timeout registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            to_color_reg  <= lfcr_pkg::RST_COLOR_TO;
            to_pixel_reg  <= lfcr_pkg::RST_PIXEL_TO;
            to_dyn_reg    <= lfcr_pkg::RST_DYN_TO;
            to_bright_reg <= lfcr_pkg::RST_BRIGHT_TO;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lfcr_pkg::REG_COLOR_TO:  to_color_reg  <= cfg.data;
                lfcr_pkg::REG_PIXEL_TO:  to_pixel_reg  <= cfg.data;
                lfcr_pkg::REG_DYN_TO:    to_dyn_reg    <= cfg.data;
                lfcr_pkg::REG_BRIGHT_TO: to_bright_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.event_res  = out_event_reg;
    assign result_out.brightness = out_bright_reg;
    assign result_out.read_red   = out_rgb_reg[23:16];
    assign result_out.read_green = out_rgb_reg[15:8];
    assign result_out.read_blue  = out_rgb_reg[7:0];
    assign result_out.mode       = out_mode_reg;

    // The timer only runs inside a data command
    a_wait_no_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == lfcr_pkg::MODE_WAIT) |-> !timer_reg)
        else $error("timer running while waiting for a command");

    // Byte count never passes a full dynamic upload
    a_bcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= lfcr_pkg::DYN_LAST)
        else $error("byte count beyond a full frame upload");

    // A tick on a running, unsaturated timer advances it by one
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && item_in.opcode == lfcr_pkg::OP_TICK && timer_reg
         && elapsed_reg != lfcr_pkg::TICK_SAT)
        |=> (elapsed_reg == 8'($past(elapsed_reg) + 8'd1)))
        else $error("tick did not advance the timeout counter");

    // Dynamic channel pointer stays on a real channel
    a_dch_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dch_reg == lfcr_pkg::CH_RED || dch_reg == lfcr_pkg::CH_GREEN
         || dch_reg == lfcr_pkg::CH_BLUE))
        else $error("dynamic channel pointer out of range");

endmodule

### hdl/lfcr_frame_store.sv
// Frame store: one-port synchronous RAM of 24-bit pixels with a registered read.
// Per-entry valid bits make unwritten pixels read as black after reset. Uses lfcr_pkg.
module lfcr_frame_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfcr_pkg::lfcr_mem_req_t req,
    output logic [23:0]             rd_data
);

    logic [23:0]                      mem [lfcr_pkg::PIXEL_COUNT];
    logic [lfcr_pkg::PIXEL_COUNT-1:0] valid_reg;
    logic [23:0]                      rdata_reg;
    logic                             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    // never-written entry reads as black
    assign rd_data = rvalid_reg ? rdata_reg : 24'd0;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for led_frame_command_receiver_core: directed table, then random
// traffic under several pacing phases.
// Depends on lfcr_pkg, the channel interfaces in lfcr_if and the receiver core RTL.
module tb_top;

    // The package names only the three live opcodes; the fourth one must do nothing.
    localparam logic [1:0] OP_SPARE = 2'd3;
    // A timeout at or below this one is cheap enough to run out with ticks.
    localparam logic [7:0] QUICK_TIMEOUT = 8'd20;
    // Cycles without any accepted word before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 3000;
    // Longest time a result may need: a color fill plus the output register.
    localparam int unsigned DRAIN_TAIL = 2 * (lfcr_pkg::PIXEL_COUNT + 2);
    // Idle percentages: heavy in the single-side phases, light when both sides idle.
    localparam int unsigned HEAVY_IDLE_PCT = 84;
    localparam int unsigned LIGHT_IDLE_PCT = 6;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SRC_IDLE,
        PACE_SINK_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] bright;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] mode;
    } result_t;

    // One directed word; want holds the typed-in result where fixed is set.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] ridx;
        logic       fixed;
        result_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lfcr_in_if  word_in ();
    lfcr_out_if word_out ();
    lfcr_cfg_if cfg_ch ();

    led_frame_command_receiver_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (word_in),
        .result_out (word_out),
        .cfg        (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Directed table. Typed results are the ones plain from the spec: reset
    // contents, a full color command, a pixel write, blank, ignored bytes.
    // ------------------------------------------------------------------
    stim_row_t directed_rows [25] = '{
        '{lfcr_pkg::OP_READ, 8'h00, 8'h00, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_COLOR}},
        '{lfcr_pkg::OP_READ, 8'hFF, 8'hFF, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_COLOR}},
        '{lfcr_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_COLOR}},
        '{OP_SPARE, 8'hFF, 8'hFF, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_COLOR}},
        '{lfcr_pkg::OP_BYTE, 8'h80, 8'h3C, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'hFF, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'h00, 8'hFF, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'hAA, 8'h55, 1'b1,
          '{lfcr_pkg::EV_SHOW, 8'h80, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_READ, 8'h00, 8'h11, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'hFF, 8'h00, 8'hAA, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_BYTE, lfcr_pkg::CMD_BLANK, 8'h00, 1'b1,
          '{lfcr_pkg::EV_BLANK, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_BYTE, 8'd99, 8'h00, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_BYTE, lfcr_pkg::CMD_PIXEL, 8'h00, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_PIXEL}},
        '{lfcr_pkg::OP_BYTE, 8'hFF, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'h01, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'h12, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'h34, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'h56, 8'h00, 1'b1,
          '{lfcr_pkg::EV_SHOW, 8'h01, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_READ, 8'h00, 8'hFF, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h12, 8'h34, 8'h56, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_BYTE, lfcr_pkg::CMD_BRIGHT, 8'h00, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_BRIGHT}},
        '{lfcr_pkg::OP_BYTE, 8'h5A, 8'h00, 1'b1,
          '{lfcr_pkg::EV_SHOW, 8'h5A, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_WAIT}},
        '{lfcr_pkg::OP_BYTE, lfcr_pkg::CMD_DYN, 8'h00, 1'b1,
          '{lfcr_pkg::EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, lfcr_pkg::MODE_DYN}},
        '{lfcr_pkg::OP_BYTE, 8'h33, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_BYTE, 8'hC4, 8'h00, 1'b0, '0},
        '{lfcr_pkg::OP_READ, 8'h00, 8'h00, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Receiver predictor: its own copy of the mode machine, buffers,
    // timeout registers and frame store.
    // ------------------------------------------------------------------
    logic [2:0] cur_mode;
    logic [9:0] byte_cnt;
    logic       timer_on;
    logic [7:0] elapsed;
    logic [7:0] color_buf [4];
    logic [7:0] pixel_buf [5];
    logic [7:0] stream_br;
    logic [7:0] fr_red   [lfcr_pkg::PIXEL_COUNT];
    logic [7:0] fr_green [lfcr_pkg::PIXEL_COUNT];
    logic [7:0] fr_blue  [lfcr_pkg::PIXEL_COUNT];
    logic [7:0] timeout_reg [4];

    result_t     awaited_results [$];
    int unsigned words_sent;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    pace_t       pace;

    // Typed-in result handed from the driver to the acceptance monitor.
    logic    fixed_valid;
    result_t fixed_result;

    function automatic void reset_model();
        cur_mode  = lfcr_pkg::MODE_COLOR;
        byte_cnt  = '0;
        timer_on  = 1'b0;
        elapsed   = '0;
        color_buf = '{lfcr_pkg::BYTE_FULL, lfcr_pkg::BYTE_FULL, 8'h00, 8'h00};
        pixel_buf = '{8'h00, lfcr_pkg::BYTE_FULL, 8'h00, 8'h00, lfcr_pkg::BYTE_FULL};
        stream_br = lfcr_pkg::BYTE_FULL;
        for (int i = 0; i < lfcr_pkg::PIXEL_COUNT; i++)
        begin
            fr_red[i]   = '0;
            fr_green[i] = '0;
            fr_blue[i]  = '0;
        end
        timeout_reg[lfcr_pkg::REG_COLOR_TO]  = lfcr_pkg::RST_COLOR_TO;
        timeout_reg[lfcr_pkg::REG_PIXEL_TO]  = lfcr_pkg::RST_PIXEL_TO;
        timeout_reg[lfcr_pkg::REG_DYN_TO]    = lfcr_pkg::RST_DYN_TO;
        timeout_reg[lfcr_pkg::REG_BRIGHT_TO] = lfcr_pkg::RST_BRIGHT_TO;
    endfunction

    function automatic logic [7:0] active_timeout();
        case (cur_mode)
            lfcr_pkg::MODE_COLOR: return timeout_reg[lfcr_pkg::REG_COLOR_TO];
            lfcr_pkg::MODE_DYN:   return timeout_reg[lfcr_pkg::REG_DYN_TO];
            lfcr_pkg::MODE_PIXEL: return timeout_reg[lfcr_pkg::REG_PIXEL_TO];
            default:              return timeout_reg[lfcr_pkg::REG_BRIGHT_TO];
        endcase
    endfunction

    // Write out whatever the open command holds, go back to waiting, and
    // return the brightness the show carries.
    function automatic logic [7:0] commit_frame();
        logic [7:0] br;
        br = stream_br;
        if (cur_mode == lfcr_pkg::MODE_COLOR)
        begin
            for (int i = 0; i < lfcr_pkg::PIXEL_COUNT; i++)
            begin
                fr_red[i]   = color_buf[1];
                fr_green[i] = color_buf[2];
                fr_blue[i]  = color_buf[3];
            end
            br = color_buf[0];
        end
        else if (cur_mode == lfcr_pkg::MODE_PIXEL)
        begin
            if (pixel_buf[0] < lfcr_pkg::PIXEL_COUNT)
            begin
                fr_red[pixel_buf[0]]   = pixel_buf[2];
                fr_green[pixel_buf[0]] = pixel_buf[3];
                fr_blue[pixel_buf[0]]  = pixel_buf[4];
            end
            br = pixel_buf[1];
        end
        byte_cnt = '0;
        timer_on = 1'b0;
        cur_mode = lfcr_pkg::MODE_WAIT;
        return br;
    endfunction

    function automatic result_t step_receiver(logic [1:0] op, logic [7:0] data,
                                              logic [7:0] ridx);
        result_t     r;
        logic        as_cmd;
        int unsigned k;
        int unsigned px;
        r = '0;
        if (op == lfcr_pkg::OP_TICK)
        begin
            if (timer_on && elapsed < lfcr_pkg::TICK_SAT)
                elapsed++;
        end
        else if (op == lfcr_pkg::OP_READ)
        begin
            if (ridx < lfcr_pkg::PIXEL_COUNT)
            begin
                r.red   = fr_red[ridx];
                r.green = fr_green[ridx];
                r.blue  = fr_blue[ridx];
            end
        end
        else if (op == lfcr_pkg::OP_BYTE)
        begin
            as_cmd = (cur_mode == lfcr_pkg::MODE_WAIT);
            // The first data byte starts the clock; a later one past the limit
            // flushes the partial command and is then read as a command itself.
            if (!as_cmd)
            begin
                if (!timer_on)
                begin
                    timer_on = 1'b1;
                    elapsed  = '0;
                end
                else if (elapsed > active_timeout())
                begin
                    r.bright = commit_frame();
                    r.ev     = lfcr_pkg::EV_SHOW;
                    as_cmd   = 1'b1;
                end
            end
            if (as_cmd)
            begin
                case (data)
                    lfcr_pkg::CMD_COLOR:  cur_mode = lfcr_pkg::MODE_COLOR;
                    lfcr_pkg::CMD_DYN:    cur_mode = lfcr_pkg::MODE_DYN;
                    lfcr_pkg::CMD_PIXEL:  cur_mode = lfcr_pkg::MODE_PIXEL;
                    lfcr_pkg::CMD_BRIGHT: cur_mode = lfcr_pkg::MODE_BRIGHT;
                    lfcr_pkg::CMD_BLANK:
                        if (r.ev == lfcr_pkg::EV_NONE)
                        begin
                            r.ev     = lfcr_pkg::EV_BLANK;
                            r.bright = '0;
                        end
                    default: ;
                endcase
            end
            else if (cur_mode == lfcr_pkg::MODE_COLOR)
            begin
                color_buf[byte_cnt[1:0]] = data;
                byte_cnt++;
                if (byte_cnt > 3)
                begin
                    r.bright = commit_frame();
                    r.ev     = lfcr_pkg::EV_SHOW;
                end
            end
            else if (cur_mode == lfcr_pkg::MODE_PIXEL)
            begin
                k = (byte_cnt > 4) ? 4 : byte_cnt;
                pixel_buf[k] = data;
                byte_cnt++;
                if (byte_cnt > 4)
                begin
                    r.bright = commit_frame();
                    r.ev     = lfcr_pkg::EV_SHOW;
                end
            end
            else if (cur_mode == lfcr_pkg::MODE_DYN)
            begin
                k = byte_cnt;
                if (k == 0)
                    stream_br = data;
                else
                begin
                    px = (k - 1) / 3;
                    if (px < lfcr_pkg::PIXEL_COUNT)
                        case (2'((k - 1) % 3))
                            lfcr_pkg::CH_RED:   fr_red[px]   = data;
                            lfcr_pkg::CH_GREEN: fr_green[px] = data;
                            default:            fr_blue[px]  = data;
                        endcase
                end
                byte_cnt++;
                if (byte_cnt > 3 * lfcr_pkg::PIXEL_COUNT)
                begin
                    r.bright = commit_frame();
                    r.ev     = lfcr_pkg::EV_SHOW;
                end
            end
            else
            begin
                stream_br = data;
                r.bright  = commit_frame();
                r.ev      = lfcr_pkg::EV_SHOW;
            end
        end
        r.mode = cur_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Monitors. All sample at the rising edge, before the core's own
    // registers move.
    // ------------------------------------------------------------------

    // Predict every accepted input word; a typed-in result overrides the
    // prediction but the predictor still advances its state.
    always @(posedge clk)
    begin : accept_mon
        result_t r;
        if (rst_n && word_in.valid && word_in.ready)
        begin
            r = step_receiver(word_in.opcode, word_in.data_byte, word_in.read_index);
            awaited_results.push_back(fixed_valid ? fixed_result : r);
        end
    end

    // Mirror register writes into the predictor.
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            timeout_reg[cfg_ch.index] = cfg_ch.data;
    end

    function automatic void flag(string msg);
        if (mismatches < 10)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            flag($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    // Compare each result word against the oldest outstanding prediction.
    always @(posedge clk)
    begin : result_mon
        result_t want;
        if (rst_n && word_out.valid && word_out.ready)
        begin
            if (awaited_results.size() == 0)
                flag("result word with no prediction outstanding");
            else
            begin
                want = awaited_results.pop_front();
                check_field("event_res",  8'(want.ev),   8'(word_out.event_res));
                check_field("brightness", want.bright,   word_out.brightness);
                check_field("read_red",   want.red,      word_out.read_red);
                check_field("read_green", want.green,    word_out.read_green);
                check_field("read_blue",  want.blue,     word_out.read_blue);
                check_field("mode",       8'(want.mode), 8'(word_out.mode));
            end
        end
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result back-pressure: hold ready low in 84% of the cycles when only the
    // sink stalls, in 6% when both sides idle.
    initial
    begin
        word_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pace == PACE_SINK_STALL)
                word_out.ready = ($urandom_range(0, 99) >= HEAVY_IDLE_PCT);
            else if (pace == PACE_BOTH)
                word_out.ready = ($urandom_range(0, 99) >= LIGHT_IDLE_PCT);
            else
                word_out.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------

    // Offer one word and hold it until the core takes it, then drop valid.
    task automatic send_word(logic [1:0] op, logic [7:0] data, logic [7:0] ridx,
                             logic typed = 1'b0, result_t want = '0);
        if (pace == PACE_SRC_IDLE)
        begin
            while ($urandom_range(0, 99) < HEAVY_IDLE_PCT)
                @(negedge clk);
        end
        else if (pace == PACE_BOTH)
        begin
            while ($urandom_range(0, 99) < LIGHT_IDLE_PCT)
                @(negedge clk);
        end
        word_in.valid      = 1'b1;
        word_in.opcode     = op;
        word_in.data_byte  = data;
        word_in.read_index = ridx;
        fixed_valid        = typed;
        fixed_result       = want;
        do
            @(posedge clk);
        while (!word_in.ready);
        words_sent++;
        @(negedge clk);
        word_in.valid = 1'b0;
    endtask

    // Unused fields carry random junk so every input bit toggles.
    task automatic send_byte(logic [7:0] b);
        send_word(lfcr_pkg::OP_BYTE, b, 8'($urandom));
    endtask

    task automatic send_tick();
        send_word(lfcr_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_read(logic [7:0] idx);
        send_word(lfcr_pkg::OP_READ, 8'($urandom), idx);
    endtask

    task automatic write_reg(logic [lfcr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Wait until every predicted result has come back.
    task automatic drain();
        while (awaited_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Bring the core back to waiting: run out the timer where it can expire,
    // otherwise feed data bytes until the command completes.
    task automatic settle_to_waiting();
        drain();
        while (cur_mode != lfcr_pkg::MODE_WAIT)
        begin
            if (timer_on && active_timeout() != lfcr_pkg::TICK_SAT)
            begin
                repeat (int'(active_timeout()) + 1)
                    send_tick();
                // Taken as a command after the flush; no command uses this range.
                send_byte(8'($urandom_range(28, 255)));
            end
            else
                send_byte(8'($urandom));
            drain();
        end
    endtask

    // One command with random content. Where the mode's timeout is short,
    // some commands stop early and are flushed by ticks; the next word then
    // lands as a command in the same step as the flush.
    task automatic send_command(logic [7:0] code, logic full);
        int unsigned body;
        int unsigned n;
        logic [7:0]  limit;
        logic        quick;
        case (code)
            lfcr_pkg::CMD_COLOR:
            begin
                body  = 4;
                limit = timeout_reg[lfcr_pkg::REG_COLOR_TO];
            end
            lfcr_pkg::CMD_PIXEL:
            begin
                body  = 5;
                limit = timeout_reg[lfcr_pkg::REG_PIXEL_TO];
            end
            lfcr_pkg::CMD_DYN:
            begin
                body  = 3 * lfcr_pkg::PIXEL_COUNT + 1;
                limit = timeout_reg[lfcr_pkg::REG_DYN_TO];
            end
            default:
            begin
                body  = 1;
                limit = timeout_reg[lfcr_pkg::REG_BRIGHT_TO];
            end
        endcase
        quick = (limit <= QUICK_TIMEOUT);
        // Skip stray uploads that could only end after hundreds of bytes.
        if (code == lfcr_pkg::CMD_DYN && !quick && !full)
            return;
        send_byte(code);
        n = body;
        if (!full && quick && body > 1
            && (code == lfcr_pkg::CMD_DYN || $urandom_range(0, 2) == 0))
            n = $urandom_range(1, (code == lfcr_pkg::CMD_DYN) ? 30 : body - 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_read(8'($urandom));
            else if ($urandom_range(0, 99) < 4)
                send_tick();
            send_byte(8'($urandom));
        end
        if (n < body)
            repeat (int'(limit) + 1 + $urandom_range(0, 2))
                send_tick();
    endtask

    task automatic send_sequence();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            send_command(lfcr_pkg::CMD_COLOR, 1'b0);
        else if (pick < 42)
            send_command(lfcr_pkg::CMD_PIXEL, 1'b0);
        else if (pick < 54)
            send_command(lfcr_pkg::CMD_BRIGHT, 1'b0);
        else if (pick < 68)
            send_command(lfcr_pkg::CMD_DYN, 1'b0);
        else if (pick < 78)
            send_byte(lfcr_pkg::CMD_BLANK);
        else if (pick < 88)
            repeat ($urandom_range(1, 3))
                send_read(8'($urandom));
        else
        begin
            // Noise: any opcode, any content. Keep mode codes out while some
            // timeout is long, or a stray command would swallow what follows.
            b = 8'($urandom);
            if (b >= lfcr_pkg::CMD_COLOR && b <= lfcr_pkg::CMD_BRIGHT
                && (timeout_reg[lfcr_pkg::REG_COLOR_TO] > QUICK_TIMEOUT
                    || timeout_reg[lfcr_pkg::REG_PIXEL_TO] > QUICK_TIMEOUT
                    || timeout_reg[lfcr_pkg::REG_DYN_TO] > QUICK_TIMEOUT))
                b = b + 8'd10;
            send_word(2'($urandom), b, 8'($urandom));
        end
    endtask

    // Reprogram the timeouts while idle, then stream random commands at the
    // given pacing until the word quota is met.
    task automatic run_phase(pace_t p, logic [7:0] color_to, logic [7:0] pixel_to,
                             logic [7:0] dyn_to, logic [7:0] bright_to,
                             int unsigned quota, logic upload);
        int unsigned stop_at;
        drain();
        pace = p;
        write_reg(lfcr_pkg::REG_COLOR_TO, color_to);
        write_reg(lfcr_pkg::REG_PIXEL_TO, pixel_to);
        write_reg(lfcr_pkg::REG_DYN_TO, dyn_to);
        write_reg(lfcr_pkg::REG_BRIGHT_TO, bright_to);
        settle_to_waiting();
        stop_at = words_sent + quota;
        if (upload)
            send_command(lfcr_pkg::CMD_DYN, 1'b1);
        while (words_sent < stop_at)
            send_sequence();
        settle_to_waiting();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_model();
        words_sent   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        pace         = PACE_FULL;
        fixed_valid  = 1'b0;
        fixed_result = '0;

        word_in.valid      = 1'b0;
        word_in.opcode     = lfcr_pkg::OP_BYTE;
        word_in.data_byte  = '0;
        word_in.read_index = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = lfcr_pkg::REG_COLOR_TO;
        cfg_ch.data        = '0;

        // Hold reset low, then release it on a falling edge.
        rst_n = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words under the reset timeouts.
        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].ridx,
                      directed_rows[i].fixed, directed_rows[i].want);

        // Zero timeouts: one tick expires any command. Back-to-back traffic.
        run_phase(PACE_FULL, 8'd0, 8'd0, 8'd0, 8'd0, 300, 1'b0);
        // Saturated timeouts never expire; includes one full-frame upload.
        run_phase(PACE_SRC_IDLE, lfcr_pkg::TICK_SAT, lfcr_pkg::TICK_SAT, lfcr_pkg::TICK_SAT,
                  lfcr_pkg::TICK_SAT, 1020, 1'b1);
        run_phase(PACE_SINK_STALL, 8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                  8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)), 280, 1'b0);
        run_phase(PACE_BOTH, 8'd3, 8'd1, 8'd2, 8'd128, 280, 1'b0);

        // Let stragglers surface before the verdict.
        pace = PACE_FULL;
        drain();
        repeat (DRAIN_TAIL)
            @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
